>>> rtl/core/spe_pkg.sv
// Shared types and constants of the shortest path engine.
// Used by spe_cell, shortest_path_engine_top and the testbench; no other dependencies.
package spe_pkg;

   localparam int unsigned DIST_W = 22;
   localparam logic [DIST_W-1:0] DIST_SAT = 22'h3FFFFF;

   typedef logic [5:0]        node_id_type;
   typedef logic [DIST_W-1:0] dist_type;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_RUN   = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_RELAX,
      ST_EMIT
   } state_type;

   // running minimum handed down the cell chain
   typedef struct packed {
      logic        valid;
      node_id_type idx;
      dist_type    path_len;
   } token_type;

   // per node result, shifted toward cell 0 while emitting
   typedef struct packed {
      logic        reached;
      dist_type    path_len;
      node_id_type pred;
      logic        has_pred;
   } record_type;

   // commands broadcast from the sequencer to every cell
   typedef struct packed {
      logic        init;
      logic        src_ok;
      node_id_type source;
      logic        settle;
      node_id_type best;
      logic        relax;
      node_id_type node_a;
      node_id_type node_b;
      dist_type    cand;
      logic        shift;
   } bcast_type;

endpackage

>>> rtl/core/spe_cell.sv
// One node cell: tentative distance, predecessor and settled mark of one node.
// Depends on spe_pkg.
module spe_cell #(
   parameter int unsigned CELL_IDX = 0
) (
   input  logic               clock,
   input  spe_pkg::bcast_type  bcast,
   input  spe_pkg::token_type  tok_in,
   output spe_pkg::token_type  tok_out,
   input  spe_pkg::record_type rec_in,
   output spe_pkg::record_type rec_out
);
   import spe_pkg::*;

   localparam node_id_type MY_ID = node_id_type'(CELL_IDX);

   record_type rec_ff, rec_in_n;
   logic       settled_ff, settled_in;
   token_type  tok_ff, tok_in_n;
   logic       eligible, match;

   always_comb begin
      eligible = rec_ff.reached && !settled_ff;
      if (eligible && (!tok_in.valid || rec_ff.path_len < tok_in.path_len)) begin
         tok_in_n = '{valid: 1'b1, idx: MY_ID, path_len: rec_ff.path_len};
      end else begin
         tok_in_n = tok_in;
      end

      match = (bcast.node_a == bcast.best && bcast.node_b == MY_ID) ||
              (bcast.node_b == bcast.best && bcast.node_a == MY_ID);

      rec_in_n   = rec_ff;
      settled_in = settled_ff;
      if (bcast.init) begin
         rec_in_n   = '{reached: bcast.src_ok && bcast.source == MY_ID,
                        path_len: '0, pred: '0, has_pred: 1'b0};
         settled_in = 1'b0;
      end else if (bcast.shift) begin
         rec_in_n = rec_in;
      end else begin
         if (bcast.settle && bcast.best == MY_ID) begin
            settled_in = 1'b1;
         end
         if (bcast.relax && match && !settled_ff &&
             (!rec_ff.reached || bcast.cand < rec_ff.path_len)) begin
            rec_in_n = '{reached: 1'b1, path_len: bcast.cand, pred: bcast.best,
                         has_pred: 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff     <= rec_in_n;
      settled_ff <= settled_in;
      tok_ff     <= tok_in_n;
   end

   assign tok_out = tok_ff;
   assign rec_out = rec_ff;

endmodule

>>> rtl/core/shortest_path_engine_top.sv
// Shortest path engine: a row of node cells driven by an edge sequencer.
// Depends on spe_pkg and spe_cell.
//
// Load and clear requests are accepted while idle and busy stays low. A run
// raises busy: an init step, then per settled node a minimum scan through
// the cell chain and a relax sweep over the stored edges in the
// single-port edge memory; after at most node_count settles (node_count
// clamped to 1..MAX_NODES) a last scan finds no candidate, and the block
// emits that clamped number of results on consecutive cycles,
// one per rsp_valid strobe, then drops busy.
// Results cannot be held off: the receiver must take each one in its strobe
// cycle.
module shortest_path_engine_top #(
   parameter int unsigned MAX_NODES   = 64,
   parameter int unsigned MAX_EDGES   = 256,
   parameter int unsigned WEIGHT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_type,
   input  logic [5:0]           req_node_a,
   input  logic [5:0]           req_node_b,
   input  logic [15:0]          req_weight,
   output logic                 rsp_valid,
   output logic [5:0]           rsp_node_index,
   output logic [21:0]          rsp_distance,
   output logic                 rsp_reachable,
   output logic [5:0]           rsp_predecessor,
   output logic                 rsp_has_predecessor,
   output logic                 rsp_edges_dropped,
   output logic                 rsp_last,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import spe_pkg::*;

   localparam int unsigned CW    = $clog2(MAX_NODES + 1);
   localparam int unsigned EW    = $clog2(MAX_EDGES + 1);
   localparam int unsigned AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned ENT_W = 12 + WEIGHT_BITS;
   localparam int unsigned SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

   // configuration registers
   logic [6:0] node_count_ff;
   logic [5:0] source_node_ff;
   logic       cfg_wr;
   logic [6:0] n_eff;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff  <= 7'd64;
         source_node_ff <= '0;
      end else if (cfg_wr) begin
         if (paddr[2]) source_node_ff <= pwdata[5:0];
         else          node_count_ff  <= pwdata[6:0];
      end
   end

   assign prdata = paddr[2] ? {26'd0, source_node_ff} : {25'd0, node_count_ff};

   always_comb begin
      if (node_count_ff == 7'd0)                  n_eff = 7'd1;
      else if (node_count_ff > 7'(MAX_NODES))     n_eff = 7'(MAX_NODES);
      else                                        n_eff = node_count_ff;
   end

   // edge store
   logic [ENT_W-1:0] edge_mem [MAX_EDGES];
   logic [ENT_W-1:0] mem_q_ff;
   logic [EW-1:0]    edge_total_ff, edge_total_in;
   logic             drop_ff, drop_in;
   logic             accept, load_ok, mem_we;
   logic [AW-1:0]    mem_addr;

   assign accept  = start && !busy;
   assign load_ok = (edge_total_ff < EW'(MAX_EDGES)) &&
                    ({1'b0, req_node_a} < n_eff) && ({1'b0, req_node_b} < n_eff);
   assign mem_we  = accept && req_type == REQ_LOAD && load_ok;

   // sequencer
   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [EW-1:0] issue_ff, issue_in;
   logic          v1_ff, v1_in, v2_ff, v2_in;
   node_id_type   best_ff, best_in;
   dist_type      best_dist_ff, best_dist_in;
   logic [5:0]    q_a, q_b;
   logic [SUM_W-1:0] sum;
   logic          q_ok;
   node_id_type   r_a_ff, r_b_ff;
   dist_type      cand_ff;
   logic          r_ok_ff;
   bcast_type     bcast;
   token_type     tok [MAX_NODES+1];
   record_type    rec [MAX_NODES+1];

   assign mem_addr = (state_ff == ST_RELAX) ? issue_ff[AW-1:0] : edge_total_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) edge_mem[mem_addr] <= {req_node_a, req_node_b, WEIGHT_BITS'(req_weight)};
      mem_q_ff <= edge_mem[mem_addr];
   end

   assign q_a = mem_q_ff[ENT_W-1 -: 6];
   assign q_b = mem_q_ff[ENT_W-7 -: 6];
   assign q_ok = ({1'b0, q_a} < n_eff) && ({1'b0, q_b} < n_eff);
   assign sum = SUM_W'(best_dist_ff) + SUM_W'(mem_q_ff[WEIGHT_BITS-1:0]);

   // relax stage: saturated candidate distance
   always_ff @(posedge clock) begin
      r_a_ff  <= q_a;
      r_b_ff  <= q_b;
      r_ok_ff <= q_ok;
      cand_ff <= (sum > SUM_W'(DIST_SAT)) ? DIST_SAT : sum[DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         issue_ff      <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         edge_total_ff <= '0;
         drop_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         issue_ff      <= issue_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         edge_total_ff <= edge_total_in;
         drop_ff       <= drop_in;
      end
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      issue_in      = issue_ff;
      v1_in         = 1'b0;
      v2_in         = v1_ff;
      best_in       = best_ff;
      best_dist_in  = best_dist_ff;
      edge_total_in = edge_total_ff;
      drop_in       = drop_ff;
      bcast         = '0;
      bcast.source  = source_node_ff;
      bcast.src_ok  = {1'b0, source_node_ff} < n_eff;
      bcast.best    = best_ff;
      bcast.node_a  = r_a_ff;
      bcast.node_b  = r_b_ff;
      bcast.cand    = cand_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_code_type'(req_type))
                  REQ_LOAD: begin
                     if (load_ok) edge_total_in = edge_total_ff + 1'b1;
                     else         drop_in = 1'b1;
                  end
                  REQ_CLEAR: begin
                     edge_total_in = '0;
                     drop_in       = 1'b0;
                  end
                  REQ_RUN:  state_in = ST_INIT;
                  REQ_NONE: state_in = ST_IDLE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_INIT: begin
            bcast.init = 1'b1;
            cnt_in     = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (cnt_ff == CW'(MAX_NODES)) begin
               cnt_in = '0;
               if (tok[MAX_NODES].valid) begin
                  bcast.settle = 1'b1;
                  bcast.best   = tok[MAX_NODES].idx;
                  best_in      = tok[MAX_NODES].idx;
                  best_dist_in = tok[MAX_NODES].path_len;
                  issue_in     = '0;
                  state_in     = ST_RELAX;
               end else begin
                  state_in = ST_EMIT;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RELAX: begin
            bcast.relax = v2_ff && r_ok_ff;
            if (issue_ff < edge_total_ff) begin
               v1_in    = 1'b1;
               issue_in = issue_ff + 1'b1;
            end else if (!v1_ff && !v2_ff) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_EMIT: begin
            bcast.shift = 1'b1;
            if (7'(cnt_ff) == n_eff - 7'd1) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // node cell chain
   assign tok[0]         = '0;
   assign rec[MAX_NODES] = '0;

   for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
      spe_cell #(.CELL_IDX(g)) u_cell (
         .clock   (clock),
         .bcast   (bcast),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1]),
         .rec_in  (rec[g+1]),
         .rec_out (rec[g])
      );
   end

   assign busy                = state_ff != ST_IDLE;
   assign rsp_valid           = state_ff == ST_EMIT;
   assign rsp_node_index      = 6'(cnt_ff);
   assign rsp_reachable       = rec[0].reached;
   assign rsp_distance        = rec[0].reached ? rec[0].path_len : '0;
   assign rsp_has_predecessor = rec[0].reached && rec[0].has_pred;
   assign rsp_predecessor     = rsp_has_predecessor ? rec[0].pred : '0;
   assign rsp_edges_dropped   = drop_ff;
   assign rsp_last            = 7'(cnt_ff) == n_eff - 7'd1;

endmodule

>>> verif/testbench.sv
// Self-checking testbench of shortest_path_engine_top: edge loads, runs, clears
// and register writes, with results checked against a built-in path predictor.
// Depends on spe_pkg and the shortest_path_engine_top RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import spe_pkg::*;

   localparam int unsigned NODES      = 64;
   localparam int unsigned EDGES      = 256;
   localparam logic [2:0]  ADDR_COUNT = 3'd0;
   localparam logic [2:0]  ADDR_SRC   = 3'd4;
   localparam int unsigned STALL_LIMIT = 200000;
   localparam int unsigned ITEM_GOAL   = 470;

   typedef struct packed {
      node_id_type index;
      dist_type    path_len;
      logic        reach;
      node_id_type pred;
      logic        has_pred;
      logic        dropped;
      logic        last;
   } node_result_type;

   class path_scoreboard;
      node_id_type   edge_a [EDGES];
      node_id_type   edge_b [EDGES];
      logic [15:0]   edge_w [EDGES];
      int unsigned   edge_total;
      logic          drop_flag;
      int unsigned   node_count;
      int unsigned   source;
      node_result_type expected_nodes[$];
      int unsigned   errors;

      function new();
         edge_total = 0;
         drop_flag  = 1'b0;
         node_count = 64;
         source     = 0;
         errors     = 0;
      endfunction

      function int unsigned live_nodes();
         if (node_count == 0) return 1;
         if (node_count > NODES) return NODES;
         return node_count;
      endfunction

      function void note_input(req_code_type kind, node_id_type a, node_id_type b,
                               logic [15:0] w);
         int unsigned     n;
         longint unsigned path_len [NODES];
         bit              reach [NODES];
         bit              done [NODES];
         bit              has_pred [NODES];
         int unsigned     pred [NODES];
         int unsigned     best;
         longint unsigned cand;
         int unsigned     from, to;
         node_result_type r;
         n = live_nodes();
         case (kind)
            REQ_LOAD: begin
               if (edge_total >= EDGES || a >= n || b >= n) drop_flag = 1'b1;
               else begin
                  edge_a[edge_total] = a;
                  edge_b[edge_total] = b;
                  edge_w[edge_total] = w;
                  edge_total++;
               end
            end
            REQ_CLEAR: begin
               edge_total = 0;
               drop_flag  = 1'b0;
            end
            REQ_RUN: begin
               for (int i = 0; i < NODES; i++) begin
                  path_len[i] = 0; reach[i] = 0; done[i] = 0; has_pred[i] = 0; pred[i] = 0;
               end
               if (source < n) begin
                  reach[source] = 1;
                  for (int it = 0; it < n; it++) begin
                     best = n;
                     for (int i = 0; i < n; i++)
                        if (reach[i] && !done[i] &&
                            (best == n || path_len[i] < path_len[best]))
                           best = i;
                     if (best == n) break;
                     done[best] = 1;
                     for (int e = 0; e < edge_total; e++) begin
                        if (edge_a[e] >= n || edge_b[e] >= n) continue;
                        // both endpoints may match on a self loop; neither changes anything
                        for (int side = 0; side < 2; side++) begin
                           from = side ? edge_b[e] : edge_a[e];
                           to   = side ? edge_a[e] : edge_b[e];
                           if (from != best || done[to]) continue;
                           cand = path_len[best] + edge_w[e];
                           if (cand > DIST_SAT) cand = DIST_SAT;
                           if (!reach[to] || cand < path_len[to]) begin
                              path_len[to] = cand; reach[to] = 1; pred[to] = best;
                              has_pred[to] = 1;
                           end
                        end
                     end
                  end
               end
               for (int i = 0; i < n; i++) begin
                  r.index    = node_id_type'(i);
                  r.path_len = reach[i] ? dist_type'(path_len[i]) : '0;
                  r.reach    = reach[i];
                  r.pred     = (reach[i] && has_pred[i]) ? node_id_type'(pred[i]) : '0;
                  r.has_pred = reach[i] && has_pred[i];
                  r.dropped  = drop_flag;
                  r.last     = (i == n - 1);
                  expected_nodes.insert(expected_nodes.size(), r);
               end
            end
            default: ;
         endcase
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $time);
         errors++;
      endtask

      task check(node_result_type got);
         node_result_type want;
         if (expected_nodes.size() == 0) begin
            report("unexpected node result, index", got.index, 0);
            return;
         end
         want = expected_nodes.pop_front();
         if (got.index !== want.index) report("node_index", got.index, want.index);
         if (got.path_len !== want.path_len)
            report("distance", got.path_len, want.path_len);
         if (got.reach !== want.reach) report("reachable", got.reach, want.reach);
         if (got.pred !== want.pred) report("predecessor", got.pred, want.pred);
         if (got.has_pred !== want.has_pred)
            report("has_predecessor", got.has_pred, want.has_pred);
         if (got.dropped !== want.dropped)
            report("edges_dropped", got.dropped, want.dropped);
         if (got.last !== want.last) report("last", got.last, want.last);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = REQ_NONE;
   logic [5:0]  req_node_a = '0;
   logic [5:0]  req_node_b = '0;
   logic [15:0] req_weight = '0;
   logic        rsp_valid;
   logic [5:0]  rsp_node_index;
   logic [21:0] rsp_distance;
   logic        rsp_reachable;
   logic [5:0]  rsp_predecessor;
   logic        rsp_has_predecessor;
   logic        rsp_edges_dropped;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   path_scoreboard paths = new();
   logic        busy_seen = 1'b1;
   int unsigned quiet_cycles = 0;
   int unsigned items_sent = 0;

   shortest_path_engine_top u_dut (.*);

   always #5 clock = ~clock;

   // inputs only move at rising edges, so mid-cycle samples hold for the next edge
   always @(negedge clock) begin
      busy_seen <= busy;
      if (!reset && rsp_valid)
         paths.check({rsp_node_index, rsp_distance, rsp_reachable, rsp_predecessor,
                      rsp_has_predecessor, rsp_edges_dropped, rsp_last});
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("shortest_path_engine_top regression: fail");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   task automatic pause(int unsigned cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic int unsigned random_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // present one request and hold it until the transfer completes
   task automatic send(req_code_type kind, node_id_type a, node_id_type b,
                       logic [15:0] w, bit gaps);
      start      <= 1'b1;
      req_type   <= kind;
      req_node_a <= a;
      req_node_b <= b;
      req_weight <= w;
      do @(posedge clock); while (busy_seen);
      paths.note_input(kind, a, b, w);
      if (kind != REQ_NONE) items_sent++;
      if (gaps) pause(random_gap());
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (paths.expected_nodes.size() != 0 || busy_seen);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_COUNT) paths.node_count = 32'(value[6:0]);
      else paths.source = 32'(value[5:0]);
   endtask

   task automatic configure(int unsigned count, int unsigned src);
      drain();
      csr_write(ADDR_COUNT, count);
      csr_write(ADDR_SRC, src);
   endtask

   function automatic logic [15:0] random_weight();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0) return 16'd0;
      if (roll == 1) return 16'hFFFF;
      if (roll < 6) return 16'($urandom_range(20));
      return 16'($urandom);
   endfunction

   initial begin
      int unsigned n, loads;
      bit          gaps;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default sizing, extremes of every field, self loop, ignored request
      send(REQ_LOAD, 0, 1, 16'hFFFF, 0);
      send(REQ_LOAD, 1, 2, 16'd0, 0);
      send(REQ_LOAD, 0, 63, 16'd1, 1);
      send(REQ_LOAD, 63, 2, 16'd3, 1);
      send(REQ_LOAD, 5, 5, 16'd7, 0);
      send(REQ_LOAD, 2, 42, 16'hAAAA, 0);
      send(REQ_LOAD, 42, 21, 16'h5555, 0);
      send(REQ_NONE, 63, 63, 16'hFFFF, 0);
      send(REQ_RUN, 0, 0, 16'd0, 1);
      // shrink the graph: stale edges skipped, out-of-range endpoints dropped
      configure(4, 2);
      send(REQ_LOAD, 3, 10, 16'd4, 0);
      send(REQ_LOAD, 2, 3, 16'd9, 0);
      send(REQ_LOAD, 3, 0, 16'd1, 0);
      send(REQ_RUN, 0, 0, 16'd0, 0);
      send(REQ_CLEAR, 0, 0, 16'd0, 1);
      send(REQ_RUN, 0, 0, 16'd0, 1);
      configure(0, 0);
      send(REQ_LOAD, 0, 0, 16'd5, 0);
      send(REQ_LOAD, 0, 1, 16'd5, 0);
      send(REQ_RUN, 0, 0, 16'd0, 0);
      configure(127, 63);
      send(REQ_RUN, 0, 0, 16'd0, 0);
      configure(5, 9);
      send(REQ_RUN, 0, 0, 16'd0, 0);

      // fill the store past capacity on a small graph
      configure(8, 3);
      send(REQ_CLEAR, 0, 0, 16'd0, 0);
      for (int i = 0; i < EDGES + 6; i++)
         send(REQ_LOAD, node_id_type'($urandom_range(7)), node_id_type'($urandom_range(7)),
              random_weight(), 0);
      send(REQ_RUN, 0, 0, 16'd0, 1);

      while (items_sent < ITEM_GOAL) begin
         case ($urandom_range(9))
            0: n = 64;
            1: n = $urandom_range(127, 65);
            2: n = $urandom_range(1);
            3: n = $urandom_range(63, 13);
            default: n = $urandom_range(12, 2);
         endcase
         configure(n, ($urandom_range(7) == 0) ? $urandom_range(63) :
                      $urandom_range((n == 0) ? 0 : ((n > NODES) ? NODES : n) - 1));
         gaps = $urandom_range(3) != 0;
         if ($urandom_range(9) < 7) send(REQ_CLEAR, 0, 0, 16'd0, gaps);
         loads = $urandom_range(24);
         for (int i = 0; i < loads; i++) begin
            int unsigned roll, top;
            roll = $urandom_range(19);
            top  = paths.live_nodes() - 1;
            if (roll == 0)
               send(REQ_NONE, node_id_type'($urandom), node_id_type'($urandom),
                    16'($urandom), gaps);
            else if (roll < 3)
               send(REQ_LOAD, node_id_type'($urandom_range(63)),
                    node_id_type'($urandom_range(63)), 16'($urandom), gaps);
            else
               send(REQ_LOAD, node_id_type'($urandom_range(top)),
                    node_id_type'($urandom_range(top)), random_weight(), gaps);
         end
         send(REQ_RUN, node_id_type'($urandom), node_id_type'($urandom), 16'($urandom),
              gaps);
         if ($urandom_range(3) == 0) send(REQ_RUN, 0, 0, 16'd0, gaps);
      end

      drain();
      repeat (20) @(posedge clock);
      if (paths.errors == 0 && paths.expected_nodes.size() == 0)
         $display("shortest_path_engine_top regression: pass");
      else
         $display("shortest_path_engine_top regression: fail");
      $finish;
   end
endmodule

>>> shortest_path_engine_top.f
rtl/core/spe_pkg.sv
rtl/core/spe_cell.sv
rtl/core/shortest_path_engine_top.sv
verif/testbench.sv
